>>> hw/rtl/glu_pkg.sv
package glu_pkg;

    // Operand width used inside the datapath (8 to 32); port widths stay fixed.
    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_WIDTH     = $clog2(OPERAND_WIDTH);
    localparam int STEP_WIDTH    = 3;

    // Datapath operations selected by the control word
    localparam logic [2:0] OP_NOP    = 3'd0;
    localparam logic [2:0] OP_DIV_YX = 3'd1;  // y <= y % x
    localparam logic [2:0] OP_DIV_XY = 3'd2;  // x <= x % y
    localparam logic [2:0] OP_DIV_AG = 3'd3;  // x <= a / g
    localparam logic [2:0] OP_MUL    = 3'd4;  // m <= x * b
    localparam logic [2:0] OP_EMIT   = 3'd5;  // present result, go idle

    // Jump conditions
    localparam logic [2:0] COND_NONE   = 3'd0;
    localparam logic [2:0] COND_X_ZERO = 3'd1;
    localparam logic [2:0] COND_Y_ZERO = 3'd2;
    localparam logic [2:0] COND_G_ZERO = 3'd3;
    localparam logic [2:0] COND_ALWAYS = 3'd4;

    // GCD register load on a taken jump
    localparam logic [1:0] GSEL_KEEP = 2'd0;
    localparam logic [1:0] GSEL_X    = 2'd1;
    localparam logic [1:0] GSEL_Y    = 2'd2;

    // Program addresses
    localparam logic [STEP_WIDTH-1:0] STEP_TEST_X  = 3'd0;
    localparam logic [STEP_WIDTH-1:0] STEP_MOD_Y   = 3'd1;
    localparam logic [STEP_WIDTH-1:0] STEP_TEST_Y  = 3'd2;
    localparam logic [STEP_WIDTH-1:0] STEP_MOD_X   = 3'd3;
    localparam logic [STEP_WIDTH-1:0] STEP_TEST_G  = 3'd4;
    localparam logic [STEP_WIDTH-1:0] STEP_QUOT    = 3'd5;
    localparam logic [STEP_WIDTH-1:0] STEP_PROD    = 3'd6;
    localparam logic [STEP_WIDTH-1:0] STEP_EMIT    = 3'd7;

    typedef struct packed {
        logic [2:0]            op;
        logic [2:0]            cond;
        logic [1:0]            gsel;
        logic [STEP_WIDTH-1:0] target;
    } uword_t;

    typedef struct packed {
        logic start;
        logic mul;   // 1: shift-add multiply, 0: restoring divide
    } arith_cmd_t;

    function automatic uword_t ucode_rom(input logic [STEP_WIDTH-1:0] step);
        uword_t w;
        begin
            w = '{op: OP_NOP, cond: COND_NONE, gsel: GSEL_KEEP, target: STEP_TEST_X};
            case (step)
                STEP_TEST_X:
                    w = '{op: OP_NOP, cond: COND_X_ZERO, gsel: GSEL_Y, target: STEP_TEST_G};
                STEP_MOD_Y:
                    w = '{op: OP_DIV_YX, cond: COND_NONE, gsel: GSEL_KEEP, target: STEP_TEST_X};
                STEP_TEST_Y:
                    w = '{op: OP_NOP, cond: COND_Y_ZERO, gsel: GSEL_X, target: STEP_TEST_G};
                STEP_MOD_X:
                    w = '{op: OP_DIV_XY, cond: COND_ALWAYS, gsel: GSEL_KEEP,
                          target: STEP_TEST_X};
                STEP_TEST_G:
                    w = '{op: OP_NOP, cond: COND_G_ZERO, gsel: GSEL_KEEP, target: STEP_EMIT};
                STEP_QUOT:
                    w = '{op: OP_DIV_AG, cond: COND_NONE, gsel: GSEL_KEEP, target: STEP_TEST_X};
                STEP_PROD:
                    w = '{op: OP_MUL, cond: COND_NONE, gsel: GSEL_KEEP, target: STEP_TEST_X};
                STEP_EMIT:
                    w = '{op: OP_EMIT, cond: COND_NONE, gsel: GSEL_KEEP, target: STEP_TEST_X};
                default:
                    w = '{op: OP_NOP, cond: COND_NONE, gsel: GSEL_KEEP, target: STEP_TEST_X};
            endcase
            return w;
        end
    endfunction

endpackage

>>> hw/rtl/glu_arith.sv
module glu_arith
    import glu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  arith_cmd_t               cmd,
    input  logic [OPERAND_WIDTH-1:0] opa,   // dividend or multiplier
    input  logic [OPERAND_WIDTH-1:0] opb,   // divisor or multiplicand
    output logic                     done,
    output logic [OPERAND_WIDTH-1:0] hi,    // remainder or product high half
    output logic [OPERAND_WIDTH-1:0] lo     // quotient or product low half
);

    logic                     active_reg, active_next;
    logic                     done_reg, done_next;
    logic                     mul_reg, mul_next;
    logic [CNT_WIDTH-1:0]     cnt_reg, cnt_next;
    logic [OPERAND_WIDTH-1:0] hi_reg, hi_next;
    logic [OPERAND_WIDTH-1:0] lo_reg, lo_next;
    logic [OPERAND_WIDTH-1:0] den_reg, den_next;

    logic [OPERAND_WIDTH:0]   trial;
    logic [OPERAND_WIDTH:0]   diff;
    logic                     ge;
    logic [OPERAND_WIDTH:0]   sum;

    always_comb
    begin
        trial = {hi_reg, lo_reg[OPERAND_WIDTH-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = (trial >= {1'b0, den_reg});
        sum   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, den_reg} : '0);

        active_next = active_reg;
        done_next   = 1'b0;
        mul_next    = mul_reg;
        cnt_next    = cnt_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        den_next    = den_reg;

        if (cmd.start)
        begin
            // load: dividend/multiplier into lo, clear the accumulator
            active_next = 1'b1;
            mul_next    = cmd.mul;
            cnt_next    = '0;
            hi_next     = '0;
            lo_next     = opa;
            den_next    = opb;
        end
        else if (active_reg)
        begin
            if (mul_reg)
            begin
                hi_next = sum[OPERAND_WIDTH:1];
                lo_next = {sum[0], lo_reg[OPERAND_WIDTH-1:1]};
            end
            else
            begin
                hi_next = ge ? diff[OPERAND_WIDTH-1:0] : trial[OPERAND_WIDTH-1:0];
                lo_next = {lo_reg[OPERAND_WIDTH-2:0], ge};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_WIDTH'(OPERAND_WIDTH - 1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            mul_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            active_reg <= active_next;
            done_reg   <= done_next;
            mul_reg    <= mul_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg  <= hi_next;
        lo_reg  <= lo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign hi   = hi_reg;
    assign lo   = lo_reg;

endmodule

>>> hw/rtl/gcd_lcm_unit.sv
// GCD and LCM of two unsigned operands.
//
// Command channel: drive first_operand/second_operand and raise start; the
// transfer happens at a rising edge where start is high and busy is low.
// busy stays high until the result has been presented; one item at a time.
//
// Result channel: done is high for exactly one cycle with divisor_result
// (gcd) and multiple_result (exact 64-bit lcm) valid in that cycle. The
// receiver cannot stall; results hold only until the next transfer starts.
//
// Latency is data dependent. A small microprogram steps a shared shift/
// subtract unit, which also does the shift-add multiply, through every
// remainder of Euclid's loop, the quotient a/g and the product (a/g)*b;
// test steps between them check a register for zero. The next command
// can be taken in the cycle done is high.
//
// Reset (rst_n low, asynchronous) drops busy and done and returns the
// sequencer to its first step; data registers are not cleared.
module gcd_lcm_unit
    import glu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] first_operand,
    input  logic [31:0] second_operand,
    output logic        done,
    output logic [31:0] divisor_result,
    output logic [63:0] multiple_result
);

    logic                       busy_reg, busy_next;
    logic                       wait_reg, wait_next;   // waiting on arith unit
    logic                       done_reg, done_next;
    logic [STEP_WIDTH-1:0]      step_reg, step_next;

    logic [OPERAND_WIDTH-1:0]   a_reg, a_next;
    logic [OPERAND_WIDTH-1:0]   b_reg, b_next;
    logic [OPERAND_WIDTH-1:0]   x_reg, x_next;
    logic [OPERAND_WIDTH-1:0]   y_reg, y_next;
    logic [OPERAND_WIDTH-1:0]   g_reg, g_next;
    logic [2*OPERAND_WIDTH-1:0] m_reg, m_next;

    uword_t                     uw;
    logic                       cond_true;
    logic                       accept;
    arith_cmd_t                 acmd;
    logic [OPERAND_WIDTH-1:0]   aopa;
    logic [OPERAND_WIDTH-1:0]   aopb;
    logic                       adone;
    logic [OPERAND_WIDTH-1:0]   ahi;
    logic [OPERAND_WIDTH-1:0]   alo;

    assign accept = start && !busy_reg;

    // fetch the control word for the current step
    assign uw = ucode_rom(step_reg);

    always_comb
    begin
        case (uw.cond)
            COND_NONE:   cond_true = 1'b0;
            COND_X_ZERO: cond_true = (x_reg == '0);
            COND_Y_ZERO: cond_true = (y_reg == '0);
            COND_G_ZERO: cond_true = (g_reg == '0);
            COND_ALWAYS: cond_true = 1'b1;
            default:     cond_true = 1'b0;
        endcase
    end

    // route operands of the shared unit according to the step's operation
    always_comb
    begin
        case (uw.op)
            OP_DIV_YX:
            begin
                aopa = y_reg;
                aopb = x_reg;
            end
            OP_DIV_XY:
            begin
                aopa = x_reg;
                aopb = y_reg;
            end
            OP_DIV_AG:
            begin
                aopa = a_reg;
                aopb = g_reg;
            end
            OP_MUL:
            begin
                aopa = x_reg;
                aopb = b_reg;
            end
            default:
            begin
                aopa = x_reg;
                aopb = y_reg;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        wait_next = wait_reg;
        done_next = 1'b0;
        step_next = step_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        g_next    = g_reg;
        m_next    = m_reg;
        acmd      = '{start: 1'b0, mul: 1'b0};

        if (accept)
        begin
            // take operands modulo 2^OPERAND_WIDTH, clear results
            a_next    = first_operand[OPERAND_WIDTH-1:0];
            b_next    = second_operand[OPERAND_WIDTH-1:0];
            x_next    = first_operand[OPERAND_WIDTH-1:0];
            y_next    = second_operand[OPERAND_WIDTH-1:0];
            g_next    = '0;
            m_next    = '0;
            busy_next = 1'b1;
            wait_next = 1'b0;
            step_next = STEP_TEST_X;
        end
        else if (busy_reg)
        begin
            case (uw.op)
                OP_NOP:
                begin
                    if (cond_true)
                    begin
                        step_next = uw.target;
                        case (uw.gsel)
                            GSEL_X:  g_next = x_reg;
                            GSEL_Y:  g_next = y_reg;
                            default: g_next = g_reg;
                        endcase
                    end
                    else
                    begin
                        step_next = step_reg + 1'b1;
                    end
                end
                OP_DIV_YX, OP_DIV_XY, OP_DIV_AG, OP_MUL:
                begin
                    if (!wait_reg)
                    begin
                        // issue the operation and hold this step
                        acmd      = '{start: 1'b1, mul: (uw.op == OP_MUL)};
                        wait_next = 1'b1;
                    end
                    else if (adone)
                    begin
                        wait_next = 1'b0;
                        case (uw.op)
                            OP_DIV_YX: y_next = ahi;
                            OP_DIV_XY: x_next = ahi;
                            OP_DIV_AG: x_next = alo;
                            default:   m_next = {ahi, alo};
                        endcase
                        step_next = cond_true ? uw.target : step_reg + 1'b1;
                    end
                end
                OP_EMIT:
                begin
                    done_next = 1'b1;
                    busy_next = 1'b0;
                    step_next = STEP_TEST_X;
                end
                default:
                begin
                    busy_next = 1'b0;
                    step_next = STEP_TEST_X;
                end
            endcase
        end
    end

    glu_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (acmd),
        .opa   (aopa),
        .opb   (aopb),
        .done  (adone),
        .hi    (ahi),
        .lo    (alo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            wait_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= STEP_TEST_X;
        end
        else
        begin
            busy_reg <= busy_next;
            wait_reg <= wait_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        x_reg <= x_next;
        y_reg <= y_next;
        g_reg <= g_next;
        m_reg <= m_next;
    end

    assign busy            = busy_reg;
    assign done            = done_reg;
    assign divisor_result  = 32'(g_reg);
    assign multiple_result = 64'(m_reg);

endmodule

>>> tb/sv/gcd_lcm_checker.sv
`timescale 1ns / 100ps

module gcd_lcm_checker
    import glu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [31:0]       first_operand,
    input  logic [31:0]       second_operand,
    input  logic              done,
    input  logic [31:0]       divisor_result,
    input  logic [63:0]       multiple_result,
    output int unsigned       mismatches,
    output int unsigned       pending
);

    typedef struct packed {
        logic [31:0] divisor;
        logic [63:0] multiple;
    } gcd_lcm_t;

    gcd_lcm_t expected_results[$];

    // Euclid with alternating remainders, operands cut to the datapath width
    function automatic gcd_lcm_t gcd_lcm_of(input logic [31:0] a_in, input logic [31:0] b_in);
        logic [31:0] mask;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] g;
        logic        fin;
        gcd_lcm_t    r;
        mask = (OPERAND_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << OPERAND_WIDTH) - 32'd1);
        a    = a_in & mask;
        b    = b_in & mask;
        x    = a;
        y    = b;
        g    = '0;
        fin  = 1'b0;
        while (!fin)
        begin
            if (x == 32'd0)
            begin
                g   = y;
                fin = 1'b1;
            end
            else
            begin
                y = y % x;
                if (y == 32'd0)
                begin
                    g   = x;
                    fin = 1'b1;
                end
                else
                begin
                    x = x % y;
                end
            end
        end
        r.divisor  = g;
        r.multiple = (g == 32'd0) ? 64'd0 : ({32'd0, a / g} * {32'd0, b});
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gcd_lcm_t want;
        if (!rst_n)
        begin
            expected_results.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // Check the result first; a new command may transfer on the same edge.
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result with nothing pending: gcd %0d lcm %0d",
                                 $time, divisor_result, multiple_result);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (divisor_result !== want.divisor)
                    begin
                        if (mismatches < 10)
                            $display("%0t: divisor_result expected %0d got %0d",
                                     $time, want.divisor, divisor_result);
                        mismatches = mismatches + 1;
                    end
                    if (multiple_result !== want.multiple)
                    begin
                        if (mismatches < 10)
                            $display("%0t: multiple_result expected %0d got %0d",
                                     $time, want.multiple, multiple_result);
                        mismatches = mismatches + 1;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(gcd_lcm_of(first_operand, second_operand));
            pending = expected_results.size();
        end
    end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import glu_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] first_operand;
    logic [31:0] second_operand;
    logic        done;
    logic [31:0] divisor_result;
    logic [63:0] multiple_result;

    int unsigned mismatches;
    int unsigned pending;

    gcd_lcm_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .first_operand   (first_operand),
        .second_operand  (second_operand),
        .done            (done),
        .divisor_result  (divisor_result),
        .multiple_result (multiple_result)
    );

    gcd_lcm_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .first_operand   (first_operand),
        .second_operand  (second_operand),
        .done            (done),
        .divisor_result  (divisor_result),
        .multiple_result (multiple_result),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Present one command at the falling edge and hold it until the transfer.
    // Leave start high afterwards so back-to-back commands need no gap; the
    // next call or an idle stretch changes it at the following falling edge.
    task automatic issue_command(input logic [31:0] a, input logic [31:0] b);
        @(negedge clk);
        first_operand  <= a;
        second_operand <= b;
        start          <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Drop start for a random stretch in pct out of a hundred commands.
    // Mostly short gaps; now and then a long one so it overlaps the
    // remainder loop, the quotient and the product of the previous command.
    task automatic sender_idle(input int pct);
        int gap;
        if ($urandom_range(0, 99) < pct)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 6);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Hold off until every expected result has come back.
    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Random operand pair drawn from a few families: plain random words,
    // pairs with a large common factor, small values, a zero operand,
    // equal or multiple operands, short operands and powers of two.
    task automatic random_pair(output logic [31:0] a, output logic [31:0] b);
        logic [31:0] g;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                a = $urandom;
                b = $urandom;
            end
            3, 4:
            begin
                g = $urandom_range(1, 65535);
                a = g * $urandom_range(0, 65535);
                b = g * $urandom_range(0, 65535);
            end
            5:
            begin
                a = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
            6:
            begin
                a = $urandom_range(0, 1) ? 32'd0 : $urandom;
                b = (a == 32'd0) ? $urandom : 32'd0;
            end
            7:
            begin
                a = $urandom;
                b = $urandom_range(0, 1) ? a : a * $urandom_range(2, 7);
            end
            8:
            begin
                a = $urandom >> $urandom_range(0, 31);
                b = $urandom >> $urandom_range(0, 31);
            end
            default:
            begin
                a = $urandom << $urandom_range(0, 31);
                b = 32'd1 << $urandom_range(0, 31);
            end
        endcase
    endtask

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #20000000;
        $display("gcd_lcm_unit: mismatch");
        $finish;
    end

    initial
    begin
        logic [31:0] a;
        logic [31:0] b;
        int          pct;

        rst_n          = 1'b0;
        start          = 1'b0;
        first_operand  = '0;
        second_operand = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero operands, extremes, coprime and worst-case Euclid pairs
        issue_command(32'd0, 32'd0);
        issue_command(32'd0, 32'd77);
        issue_command(32'd91, 32'd0);
        issue_command(32'd0, 32'hFFFF_FFFF);
        issue_command(32'hFFFF_FFFF, 32'd0);
        issue_command(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue_command(32'hFFFF_FFFF, 32'd1);
        issue_command(32'd1, 32'hFFFF_FFFF);
        issue_command(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        issue_command(32'd1, 32'd1);
        issue_command(32'd12, 32'd18);
        issue_command(32'd18, 32'd12);
        issue_command(32'd2971215073, 32'd1836311903);
        issue_command(32'd1836311903, 32'd2971215073);
        issue_command(32'd4294967291, 32'd4294967279);
        issue_command(32'h8000_0000, 32'h0001_0000);
        issue_command(32'h8000_0000, 32'h8000_0000);
        issue_command(32'hAAAA_AAAA, 32'h5555_5555);
        issue_command(32'hFFFF_0000, 32'h0000_FFFF);
        issue_command(32'd65536, 32'd65521);
        drain_results();

        // Random: sender idles 36 in 100, then 50 in 100, then never
        for (int phase = 0; phase < 3; phase++)
        begin
            pct = (phase == 0) ? 36 : (phase == 1) ? 50 : 0;
            for (int n = 0; n < 330; n++)
            begin
                sender_idle(pct);
                random_pair(a, b);
                issue_command(a, b);
            end
            drain_results();
        end

        // Give a stray result time to show, then decide
        repeat (2000) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("gcd_lcm_unit: match");
        else
            $display("gcd_lcm_unit: mismatch");
        $finish;
    end

endmodule
